### src/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasteriser.
// Used by mer_ctrl, mer_dp and midpoint_ellipse_rasterizer_unit; no dependencies.
`timescale 1ns / 1ps

package mer_pkg;

  localparam int unsigned AXIS_BITS_DEF  = 10;
  localparam int unsigned COORD_BITS_DEF = 12;

  // beat kinds on the input side (tuser)
  localparam logic ACTION_START = 1'b0;
  localparam logic ACTION_STEP  = 1'b1;

  // operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AA,    // a * a
    MUL_BB,    // b * b
    MUL_A2B,   // a^2 * b
    MUL_LHS,   // a^2 * (2y - 1)
    MUL_RHS,   // b^2 * (x + 1)
    MUL_TXTX,  // (2x + 1)^2
    MUL_B2P,   // b^2 * previous product
    MUL_TYTY,  // (y - 1)^2
    MUL_A2P,   // a^2 * previous product
    MUL_A2B2,  // a^2 * b^2
    MUL_A2Y    // a^2 * y
  } mul_sel_e;

  // register update applied by the datapath
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_NOVALID,
    ACT_SET_A2,
    ACT_SET_B2,
    ACT_INIT_DEC,
    ACT_SAVE_T1,
    ACT_SAVE_T2,
    ACT_R1_UPDATE,
    ACT_SET_DEC,
    ACT_ADD4,
    ACT_SUB4_ENTER,
    ACT_R2_UPDATE
  } act_e;

  typedef struct packed {
    act_e     act;
    mul_sel_e mul;
  } mer_cmd_t;

  typedef struct packed {
    logic lhs_gt;    // region 1 test: a^2(2y-1) > 2b^2(x+1)
    logic finished;
    logic region2;
  } mer_status_t;

endpackage

### src/mer_ctrl.sv
// Sequencer of the ellipse rasteriser: handshakes and multiplier schedule.
// Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_ctrl
  import mer_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic        action_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  input  mer_status_t status_i,
  output mer_cmd_t    cmd_o
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_START1 = 5'd1;
  localparam logic [4:0] ST_START2 = 5'd2;
  localparam logic [4:0] ST_START3 = 5'd3;
  localparam logic [4:0] ST_START4 = 5'd4;
  localparam logic [4:0] ST_R1A    = 5'd5;
  localparam logic [4:0] ST_R1B    = 5'd6;
  localparam logic [4:0] ST_R1C    = 5'd7;
  localparam logic [4:0] ST_R1D    = 5'd8;
  localparam logic [4:0] ST_E1     = 5'd9;
  localparam logic [4:0] ST_E2     = 5'd10;
  localparam logic [4:0] ST_E3     = 5'd11;
  localparam logic [4:0] ST_E4     = 5'd12;
  localparam logic [4:0] ST_E5     = 5'd13;
  localparam logic [4:0] ST_E6     = 5'd14;
  localparam logic [4:0] ST_R2A    = 5'd15;
  localparam logic [4:0] ST_R2B    = 5'd16;
  localparam logic [4:0] ST_R2C    = 5'd17;
  localparam logic [4:0] ST_OUT    = 5'd18;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    cmd_o.act = ACT_NONE;
    cmd_o.mul = MUL_NONE;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (action_i == ACTION_START) begin
            cmd_o.act = ACT_LOAD;
            state_d   = ST_START1;
          end else if (status_i.finished) begin
            cmd_o.act = ACT_NOVALID;
            state_d   = ST_OUT;
          end else if (status_i.region2) begin
            state_d = ST_R2A;
          end else begin
            state_d = ST_R1A;
          end
        end
      end
      ST_START1: begin
        cmd_o.mul = MUL_AA;
        state_d   = ST_START2;
      end
      ST_START2: begin
        cmd_o.act = ACT_SET_A2;
        cmd_o.mul = MUL_BB;
        state_d   = ST_START3;
      end
      ST_START3: begin
        cmd_o.act = ACT_SET_B2;
        cmd_o.mul = MUL_A2B;
        state_d   = ST_START4;
      end
      ST_START4: begin
        cmd_o.act = ACT_INIT_DEC;
        state_d   = ST_OUT;
      end
      ST_R1A: begin
        cmd_o.mul = MUL_LHS;
        state_d   = ST_R1B;
      end
      ST_R1B: begin
        cmd_o.act = ACT_SAVE_T1;
        cmd_o.mul = MUL_RHS;
        state_d   = ST_R1C;
      end
      ST_R1C: begin
        cmd_o.act = ACT_SAVE_T2;
        state_d   = status_i.lhs_gt ? ST_R1D : ST_E1;
      end
      ST_R1D: begin
        cmd_o.act = ACT_R1_UPDATE;
        state_d   = ST_OUT;
      end
      ST_E1: begin
        cmd_o.mul = MUL_TXTX;
        state_d   = ST_E2;
      end
      ST_E2: begin
        cmd_o.mul = MUL_B2P;
        state_d   = ST_E3;
      end
      ST_E3: begin
        cmd_o.act = ACT_SET_DEC;
        cmd_o.mul = MUL_TYTY;
        state_d   = ST_E4;
      end
      ST_E4: begin
        cmd_o.mul = MUL_A2P;
        state_d   = ST_E5;
      end
      ST_E5: begin
        cmd_o.act = ACT_ADD4;
        cmd_o.mul = MUL_A2B2;
        state_d   = ST_E6;
      end
      ST_E6: begin
        cmd_o.act = ACT_SUB4_ENTER;
        state_d   = ST_R2A;
      end
      ST_R2A: begin
        cmd_o.mul = MUL_A2Y;
        state_d   = ST_R2B;
      end
      ST_R2B: begin
        cmd_o.act = ACT_SAVE_T1;
        cmd_o.mul = MUL_RHS;
        state_d   = ST_R2C;
      end
      ST_R2C: begin
        cmd_o.act = ACT_R2_UPDATE;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/mer_dp.sv
// Datapath of the ellipse rasteriser: shared multiplier, decision accumulator,
// offsets and output coordinates. Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_dp
  import mer_pkg::*;
#(
  parameter int unsigned AXIS_BITS  = AXIS_BITS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mer_cmd_t              cmd_i,
  output mer_status_t           status_o,
  input  logic [AXIS_BITS-1:0]  semi_axis_x_i,
  input  logic [AXIS_BITS-1:0]  semi_axis_y_i,
  input  logic [COORD_BITS-1:0] centre_x_i,
  input  logic [COORD_BITS-1:0] centre_y_i,
  output logic                  pixel_valid_o,
  output logic                  last_pixel_o,
  output logic [COORD_BITS:0]   right_x_o,
  output logic [COORD_BITS:0]   left_x_o,
  output logic [COORD_BITS:0]   upper_y_o,
  output logic [COORD_BITS:0]   lower_y_o
);

  localparam int unsigned MW = 2 * AXIS_BITS + 2;          // multiplier operand
  localparam int unsigned PW = 2 * MW;                     // product
  localparam int unsigned DW = (4 * AXIS_BITS + 8 > 64) ? 64 : 4 * AXIS_BITS + 8;
  localparam int unsigned SW = ((AXIS_BITS > COORD_BITS) ? AXIS_BITS : COORD_BITS) + 2;
  localparam logic [AXIS_BITS-1:0] AX_ONE = AXIS_BITS'(1);
  localparam logic [MW-1:0]        MW_ONE = MW'(1);

  logic [AXIS_BITS-1:0]   ax_q, x_q, x_d, y_q, y_d;
  logic [2*AXIS_BITS-1:0] a2_q, a2_d, b2_q, b2_d;
  logic [PW-1:0]          prod_q, prod_d, t1_q, t1_d, t2_q, t2_d;
  logic [DW-1:0]          dec_q, dec_d;
  logic [COORD_BITS-1:0]  cx_q, cy_q;
  logic                   region2_q, region2_d, finished_q, finished_d;
  logic                   valid_q, valid_d;

  logic [MW-1:0] opa, opb;
  logic [DW-1:0] a2_w, b2_w, prod_w, t1_w, t2_w, inc, base;
  logic          dec_neg, dec_pos;

  // operand selection for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd_i.mul)
      MUL_AA: begin
        opa = MW'(ax_q);
        opb = MW'(ax_q);
      end
      MUL_BB: begin
        opa = MW'(y_q);
        opb = MW'(y_q);
      end
      MUL_A2B: begin
        opa = MW'(a2_q);
        opb = MW'(y_q);
      end
      MUL_LHS: begin
        opa = MW'(a2_q);
        opb = MW'({y_q, 1'b0}) - MW_ONE;
      end
      MUL_RHS: begin
        opa = MW'(b2_q);
        opb = MW'(x_q) + MW_ONE;
      end
      MUL_TXTX: begin
        opa = MW'({x_q, 1'b1});
        opb = MW'({x_q, 1'b1});
      end
      MUL_B2P: begin
        opa = MW'(b2_q);
        opb = MW'(prod_q);
      end
      MUL_TYTY: begin
        opa = MW'(y_q) - MW_ONE;
        opb = MW'(y_q) - MW_ONE;
      end
      MUL_A2P: begin
        opa = MW'(a2_q);
        opb = MW'(prod_q);
      end
      MUL_A2B2: begin
        opa = MW'(a2_q);
        opb = MW'(b2_q);
      end
      MUL_A2Y: begin
        opa = MW'(a2_q);
        opb = MW'(y_q);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_d = PW'(opa) * PW'(opb);

  // decision arithmetic wraps at DW bits
  assign a2_w    = DW'(a2_q);
  assign b2_w    = DW'(b2_q);
  assign prod_w  = DW'(prod_q);
  assign t1_w    = DW'(t1_q);
  assign t2_w    = DW'(t2_q);
  assign dec_neg = dec_q[DW-1];
  assign dec_pos = !dec_neg && (dec_q != '0);
  assign inc     = (t2_w << 3) + (b2_w << 2);          // 4b^2(2x+3)
  assign base    = (a2_w << 3) + (a2_w << 2) - (t1_w << 3);  // 12a^2 - 8a^2 y

  always_comb begin
    x_d        = x_q;
    y_d        = y_q;
    a2_d       = a2_q;
    b2_d       = b2_q;
    t1_d       = t1_q;
    t2_d       = t2_q;
    dec_d      = dec_q;
    region2_d  = region2_q;
    finished_d = finished_q;
    valid_d    = valid_q;
    unique case (cmd_i.act)
      ACT_NONE: begin
      end
      ACT_LOAD: begin
        x_d        = '0;
        y_d        = semi_axis_y_i;
        region2_d  = 1'b0;
        finished_d = (semi_axis_y_i == '0);
        valid_d    = 1'b1;
      end
      ACT_NOVALID: begin
        valid_d = 1'b0;
      end
      ACT_SET_A2: begin
        a2_d = prod_q[2*AXIS_BITS-1:0];
      end
      ACT_SET_B2: begin
        b2_d = prod_q[2*AXIS_BITS-1:0];
      end
      ACT_INIT_DEC: begin
        dec_d = (b2_w << 2) - (prod_w << 2) + a2_w;
      end
      ACT_SAVE_T1: begin
        t1_d = prod_q;
      end
      ACT_SAVE_T2: begin
        t2_d = prod_q;
      end
      ACT_R1_UPDATE: begin
        x_d     = x_q + AX_ONE;
        valid_d = 1'b1;
        if (dec_neg) begin
          dec_d      = dec_q + inc;
          finished_d = 1'b0;
        end else begin
          // 4a^2(2y-2) = 4(a^2(2y-1) - a^2)
          dec_d      = dec_q + inc - (t1_w << 2) + (a2_w << 2);
          y_d        = y_q - AX_ONE;
          finished_d = (y_q == AX_ONE);
        end
      end
      ACT_SET_DEC: begin
        dec_d = prod_w;
      end
      ACT_ADD4: begin
        dec_d = dec_q + (prod_w << 2);
      end
      ACT_SUB4_ENTER: begin
        dec_d     = dec_q - (prod_w << 2);
        region2_d = 1'b1;
      end
      ACT_R2_UPDATE: begin
        y_d        = y_q - AX_ONE;
        finished_d = (y_q == AX_ONE);
        valid_d    = 1'b1;
        if (dec_pos) begin
          dec_d = dec_q + base;
        end else begin
          dec_d = dec_q + base + (prod_w << 3);
          x_d   = x_q + AX_ONE;
        end
      end
      default: begin
      end
    endcase
  end

  // payload
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    x_q    <= x_d;
    y_q    <= y_d;
    a2_q   <= a2_d;
    b2_q   <= b2_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    dec_q  <= dec_d;
    if (cmd_i.act == ACT_LOAD) begin
      ax_q <= semi_axis_x_i;
      cx_q <= centre_x_i;
      cy_q <= centre_y_i;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region2_q  <= 1'b0;
      finished_q <= 1'b1;
      valid_q    <= 1'b0;
    end else begin
      region2_q  <= region2_d;
      finished_q <= finished_d;
      valid_q    <= valid_d;
    end
  end

  assign status_o.lhs_gt   = {1'b0, t1_q} > {prod_q, 1'b0};
  assign status_o.finished = finished_q;
  assign status_o.region2  = region2_q;

  logic [SW-1:0] cx_ext, cy_ext, ox_ext, oy_ext;
  logic [SW-1:0] rx, lx, uy, ly;

  assign cx_ext = {{(SW-COORD_BITS){cx_q[COORD_BITS-1]}}, cx_q};
  assign cy_ext = {{(SW-COORD_BITS){cy_q[COORD_BITS-1]}}, cy_q};
  assign ox_ext = SW'(x_q);
  assign oy_ext = SW'(y_q);
  assign rx     = cx_ext + ox_ext;
  assign lx     = cx_ext - ox_ext;
  assign uy     = cy_ext + oy_ext;
  assign ly     = cy_ext - oy_ext;

  assign pixel_valid_o = valid_q;
  assign last_pixel_o  = finished_q;
  assign right_x_o     = valid_q ? rx[COORD_BITS:0] : '0;
  assign left_x_o      = valid_q ? lx[COORD_BITS:0] : '0;
  assign upper_y_o     = valid_q ? uy[COORD_BITS:0] : '0;
  assign lower_y_o     = valid_q ? ly[COORD_BITS:0] : '0;

endmodule

### src/midpoint_ellipse_rasterizer_unit.sv
// Top level of the midpoint ellipse rasteriser: stream ports, sequencer and
// datapath. Depends on mer_pkg, mer_ctrl and mer_dp.
`timescale 1ns / 1ps

// Midpoint ellipse rasteriser. A start beat (tuser = 0) loads the two
// semi-axes and the centre and returns the four mirrored pixels of the top
// point; each step beat (tuser = 1) advances one pixel, first in region 1
// (east or south-east), then in region 2 (south or south-east), and returns
// the next four quadrant pixels. The set whose vertical offset reaches zero
// carries tlast; step beats after that return tuser = 0, tlast = 1 and zero
// coordinates. A start beat while an ellipse is still being drawn simply
// restarts. Exactly one result beat follows each input beat, and one beat
// is in flight at a time: the input side is not ready again until the
// result has been taken. All products come from one shared multiplier
// with a registered product, one product per cycle, which sets the
// latency. On the step that switches regions, the region 2 decision is
// rebuilt from five products before the region 2 step is taken.

module midpoint_ellipse_rasterizer_unit
  import mer_pkg::*;
#(
  parameter int unsigned AXIS_BITS  = AXIS_BITS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned IN_W  = ((2 * AXIS_BITS + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((4 * (COORD_BITS + 1) + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // semi_axis_x, semi_axis_y, centre_x, centre_y (lowest bits first)
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // action: 0 start, 1 step
  input  logic             s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // right_x, left_x, upper_y, lower_y (lowest bits first)
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // pixel_valid
  output logic             m_axis_tuser_o,
  // last_pixel
  output logic             m_axis_tlast_o
);

  localparam int unsigned A = AXIS_BITS;
  localparam int unsigned C = COORD_BITS;

  mer_cmd_t    cmd;
  mer_status_t status;

  logic [C:0] right_x, left_x, upper_y, lower_y;

  mer_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .action_i  (s_axis_tuser_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  mer_dp #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .semi_axis_x_i (s_axis_tdata_i[A-1:0]),
    .semi_axis_y_i (s_axis_tdata_i[2*A-1:A]),
    .centre_x_i    (s_axis_tdata_i[2*A+C-1:2*A]),
    .centre_y_i    (s_axis_tdata_i[2*A+2*C-1:2*A+C]),
    .pixel_valid_o (m_axis_tuser_o),
    .last_pixel_o  (m_axis_tlast_o),
    .right_x_o     (right_x),
    .left_x_o      (left_x),
    .upper_y_o     (upper_y),
    .lower_y_o     (lower_y)
  );

  assign m_axis_tdata_o = OUT_W'({lower_y, upper_y, left_x, right_x});

  // one beat in flight: no input taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid_o && s_axis_tready_o))
    else $error("input accepted while result pending");

  // no datapath register update commanded while a result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cmd.act == ACT_NONE))
    else $error("datapath update during result beat");

  // an empty result is always marked last and carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("empty result not last or not zero");

  // a start beat always enters the start sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == ACTION_START)
      |=> (cmd.act == ACT_NONE && cmd.mul == MUL_AA))
    else $error("start beat did not enter the start sequence");

endmodule
